FILE: rtl/gbt_pkg.sv
// Shared types and constants for the GBM barrier-touch path stepper.
// No dependencies; every other rtl file imports this package.
`default_nettype none
package gbt_pkg;

    typedef struct packed {
        logic signed [15:0] normal_sample;
        logic               negate_sample;
        logic               last_step;
    } in_item_t;

    typedef struct packed {
        logic        path_touched;
        logic [31:0] touched_total;
        logic [31:0] paths_total;
    } out_item_t;

    // Growth factor for one step (unsigned Q.24) and its end-of-path mark.
    typedef struct packed {
        logic [35:0] growth;
        logic        last;
    } exp_item_t;

    typedef enum logic [3:0] {
        F_IDLE, F_MZ, F_X, F_M2, F_P2, F_M3, F_P3, F_M4, F_P4, F_D6, F_D24, F_SUM
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE, B_MUL, B_UPD
    } back_state_t;

    localparam logic [2:0] REG_START   = 3'd0;
    localparam logic [2:0] REG_BARRIER = 3'd1;
    localparam logic [2:0] REG_DRIFT   = 3'd2;
    localparam logic [2:0] REG_VOL     = 3'd3;

    localparam logic signed [37:0] X_LIMIT   = 38'sd167772160;
    localparam logic signed [39:0] ONE_Q24   = 40'sd16777216;
    localparam logic [31:0]        COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [3:0]         DIV_LAST  = 4'd8;

endpackage
`default_nettype wire

FILE: rtl/gbm_barrier_touch_path.sv
// Top level of the GBM barrier-touch path stepper.
// Depends on gbt_pkg, gbt_front, gbt_queue and gbt_back.
//
// Each pushed transaction is one time step of one price path: a Q4.12 normal
// sample (optionally negated) drives x = drift + vol*z in Q8.24, clamped to
// +/-10, and the path price (Q20.12, saturating) is scaled by the fourth-order
// Taylor expansion of exp(x). The touch flag latches price >= barrier when the
// barrier lies above the start price, else price <= barrier; a start price
// equal to the barrier counts as touched. The step marked last_step pops out
// one result with the path's flag and saturating running counts of touched
// and finished paths. A step's cost is set by the front end's
// single shared multiplier (x, x^2, x^3, x^4 in turn) and its divide-by-three
// unit that retires four quotient bits a cycle; the back end's price multiply
// overlaps with the next step's front-end work.
// Write configuration only while the block is idle.
`default_nettype none
module gbm_barrier_touch_path (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire gbt_pkg::in_item_t   sample,
    output logic                     empty,
    input  wire logic                pop,
    output gbt_pkg::out_item_t       result,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);
    import gbt_pkg::*;

    logic [31:0]        start_reg;
    logic [31:0]        barrier_reg;
    logic signed [31:0] drift_reg;
    logic [30:0]        vol_reg;

    logic      fq_push, fq_full, fq_empty, bq_pop;
    exp_item_t fq_item, bq_item;

    // Hold the configuration registers; drop writes beyond the register list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= '0;
            barrier_reg <= '0;
            drift_reg   <= '0;
            vol_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START:   start_reg   <= cfg_data;
                REG_BARRIER: barrier_reg <= cfg_data;
                REG_DRIFT:   drift_reg   <= cfg_data;
                REG_VOL:     vol_reg     <= cfg_data[30:0];
                default:     ;
            endcase
        end
    end

    // Front end: accept a transaction and build its growth factor.
    gbt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .sample (sample),
        .drift  (drift_reg),
        .vol    (vol_reg),
        .q_full (fq_full),
        .q_push (fq_push),
        .q_item (fq_item)
    );

    // Decouple the two halves so each can stall on its own.
    gbt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (fq_push),
        .wr_item (fq_item),
        .q_full  (fq_full),
        .rd      (bq_pop),
        .rd_item (bq_item),
        .q_empty (fq_empty)
    );

    // Back end: advance the price, latch touches, emit finished paths.
    gbt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (fq_empty),
        .q_item  (bq_item),
        .q_pop   (bq_pop),
        .start   (start_reg),
        .barrier (barrier_reg),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
`default_nettype wire

FILE: rtl/gbt_front.sv
// Front end: takes one sample, forms x and the Taylor exp factor.
// Uses gbt_pkg; one shared multiplier and a 4-bit-a-cycle divide-by-three unit.
`default_nettype none
module gbt_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire gbt_pkg::in_item_t      sample,
    input  wire logic signed [31:0]     drift,
    input  wire logic [30:0]            vol,
    input  wire logic                   q_full,
    output logic                        q_push,
    output gbt_pkg::exp_item_t          q_item
);
    import gbt_pkg::*;

    front_state_t       state_reg, state_next;
    logic signed [16:0] z_reg, z_next;
    logic               last_reg, last_next;
    logic signed [63:0] prod_reg;
    logic signed [28:0] x_reg, x_next;
    logic signed [31:0] x2_reg, x2_next;
    logic signed [35:0] x3_reg, x3_next;
    logic [37:0]        x4_reg, x4_next;
    logic signed [35:0] t3_reg, t3_next;
    logic [35:0]        t4_reg, t4_next;
    logic [35:0]        dn_reg, dn_next;
    logic [35:0]        dq_reg, dq_next;
    logic [1:0]         dr_reg, dr_next;
    logic [3:0]         dcnt_reg, dcnt_next;

    logic signed [35:0] mul_a;
    logic signed [28:0] mul_b;
    logic signed [64:0] mul_p;
    logic signed [39:0] r24;
    logic signed [36:0] r12;
    logic signed [37:0] xsum;
    logic [35:0]        x3_mag;
    logic [35:0]        dq_full;
    logic [1:0]         dr_step;
    logic [3:0]         qbits;
    logic signed [39:0] esum;

    // Round to nearest, ties away from zero, dropping 24 or 12 fraction bits.
    function automatic logic signed [39:0] rnd24(input logic signed [63:0] p);
        logic [63:0] mag;
        logic [39:0] q;
        mag = p[63] ? 64'(-p) : 64'(p);
        q   = 40'((mag + 64'd8388608) >> 24);
        return p[63] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [36:0] rnd12(input logic signed [63:0] p);
        logic [63:0] mag;
        logic [36:0] q;
        mag = p[63] ? 64'(-p) : 64'(p);
        q   = 37'((mag + 64'd2048) >> 12);
        return p[63] ? -$signed(q) : $signed(q);
    endfunction

    always_comb
    begin
        mul_a = {{4{x_reg[28]}}, 32'(x_reg)};
        mul_b = x_reg;
        case (state_reg)
            F_MZ:    begin mul_a = {5'b0, vol}; mul_b = 29'(z_reg); end
            F_M3:    mul_a = 36'(x2_reg);
            F_M4:    mul_a = x3_reg;
            default: mul_a = 36'(x_reg);
        endcase
        mul_p = mul_a * mul_b;
    end

    assign r24    = rnd24(prod_reg);
    assign r12    = rnd12(prod_reg);
    assign xsum   = 38'(drift) + 38'(r12);
    assign x3_mag = x3_reg[35] ? 36'(-x3_reg) : 36'(x3_reg);

    // Four restoring steps of division by three; remainder stays below three.
    always_comb
    begin
        logic [2:0] r;
        r = {1'b0, dr_reg};
        for (int i = 0; i < 4; i++)
        begin
            r = {r[1:0], dn_reg[35 - i]};
            qbits[3 - i] = (r >= 3'd3);
            if (r >= 3'd3)
                r = r - 3'd3;
        end
        dr_step = r[1:0];
    end
    assign dq_full = {dq_reg[31:0], qbits};

    assign esum = ONE_Q24 + 40'(x_reg) + 40'((x2_reg + 32'sd1) >>> 1)
                + 40'(t3_reg) + 40'(t4_reg);

    always_comb
    begin
        state_next = state_reg;
        z_next = z_reg; last_next = last_reg;
        x_next = x_reg; x2_next = x2_reg; x3_next = x3_reg; x4_next = x4_reg;
        t3_next = t3_reg; t4_next = t4_reg;
        dn_next = dn_reg; dq_next = dq_reg; dr_next = dr_reg; dcnt_next = dcnt_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    z_next = sample.negate_sample ? -17'(sample.normal_sample)
                                                  : 17'(sample.normal_sample);
                    last_next  = sample.last_step;
                    state_next = F_MZ;
                end
            end
            F_MZ: state_next = F_X;
            F_X:
            begin
                if (xsum > X_LIMIT)
                    x_next = 29'(X_LIMIT);
                else if (xsum < -X_LIMIT)
                    x_next = 29'(-X_LIMIT);
                else
                    x_next = 29'(xsum);
                state_next = F_M2;
            end
            F_M2: state_next = F_P2;
            F_P2: begin x2_next = 32'(r24); state_next = F_M3; end
            F_M3: state_next = F_P3;
            F_P3: begin x3_next = 36'(r24); state_next = F_M4; end
            F_M4: state_next = F_P4;
            F_P4:
            begin
                x4_next   = 38'(r24);
                dn_next   = 36'((37'(x3_mag) + 37'd3) >> 1);
                dq_next   = '0;
                dr_next   = '0;
                dcnt_next = '0;
                state_next = F_D6;
            end
            F_D6:
            begin
                dn_next = {dn_reg[31:0], 4'b0};
                dq_next = dq_full;
                dr_next = dr_step;
                dcnt_next = dcnt_reg + 4'd1;
                if (dcnt_reg == DIV_LAST)
                begin
                    t3_next   = x3_reg[35] ? -$signed(dq_full) : $signed(dq_full);
                    dn_next   = 36'((39'(x4_reg) + 39'd12) >> 3);
                    dq_next   = '0;
                    dr_next   = '0;
                    dcnt_next = '0;
                    state_next = F_D24;
                end
            end
            F_D24:
            begin
                dn_next = {dn_reg[31:0], 4'b0};
                dq_next = dq_full;
                dr_next = dr_step;
                dcnt_next = dcnt_reg + 4'd1;
                if (dcnt_reg == DIV_LAST)
                begin
                    t4_next    = dq_full;
                    state_next = F_SUM;
                end
            end
            F_SUM:
            begin
                if (!q_full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        full          = (state_reg != F_IDLE);
        q_push        = (state_reg == F_SUM) && !q_full;
        q_item.growth = 36'(esum);
        q_item.last   = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        z_reg <= z_next; last_reg <= last_next;
        prod_reg <= 64'(mul_p);
        x_reg <= x_next; x2_reg <= x2_next; x3_reg <= x3_next; x4_reg <= x4_next;
        t3_reg <= t3_next; t4_reg <= t4_next;
        dn_reg <= dn_next; dq_reg <= dq_next; dr_reg <= dr_next; dcnt_reg <= dcnt_next;
    end

endmodule
`default_nettype wire

FILE: rtl/gbt_queue.sv
// Two-entry queue of growth factors between front and back end.
// Uses gbt_pkg for the entry type.
`default_nettype none
module gbt_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr,
    input  wire gbt_pkg::exp_item_t  wr_item,
    output logic                     q_full,
    input  wire logic                rd,
    output gbt_pkg::exp_item_t       rd_item,
    output logic                     q_empty
);
    import gbt_pkg::*;

    exp_item_t  mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        q_full   = (cnt_reg == 2'd2);
        q_empty  = (cnt_reg == 2'd0);
        rd_item  = mem_reg[rp_reg];
        cnt_next = cnt_reg + 2'(wr) - 2'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_item;
    end

endmodule
`default_nettype wire

FILE: rtl/gbt_back.sv
// Back end: scales the path price, tracks the touch flag and path counters.
// Uses gbt_pkg; holds the one-entry result register.
`default_nettype none
module gbt_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_empty,
    input  wire gbt_pkg::exp_item_t  q_item,
    output logic                     q_pop,
    input  wire logic [31:0]         start,
    input  wire logic [31:0]         barrier,
    output logic                     empty,
    input  wire logic                pop,
    output gbt_pkg::out_item_t       result
);
    import gbt_pkg::*;

    back_state_t state_reg, state_next;
    logic [35:0] growth_reg;
    logic        last_reg;
    logic [31:0] price_reg, price_next;
    logic        flag_reg, flag_next;
    logic        started_reg, started_next;
    logic [43:0] phi_reg;
    logic [55:0] plo_reg;
    logic [31:0] touched_reg, touched_next;
    logic [31:0] paths_reg, paths_next;
    logic        rvalid_reg, rvalid_next;
    out_item_t   result_reg, result_next;

    logic [44:0] scaled;
    logic [31:0] new_price;
    logic        hit;
    logic        slot_free;

    assign scaled    = 45'(phi_reg) + 45'((plo_reg + 56'd8388608) >> 24);
    assign new_price = (scaled[44:32] != '0) ? COUNT_MAX : scaled[31:0];
    assign hit       = (barrier > start) ? (new_price >= barrier) : (new_price <= barrier);
    assign slot_free = !rvalid_reg || pop;

    always_comb
    begin
        state_next   = state_reg;
        price_next   = price_reg;
        flag_next    = flag_reg;
        started_next = started_reg;
        touched_next = touched_reg;
        paths_next   = paths_reg;
        rvalid_next  = rvalid_reg && !pop;
        result_next  = result_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    if (!started_reg)
                    begin
                        price_next   = start;
                        flag_next    = (start == barrier);
                        started_next = 1'b1;
                    end
                    state_next = B_MUL;
                end
            end
            B_MUL: state_next = B_UPD;
            B_UPD:
            begin
                if (!last_reg || slot_free)
                begin
                    price_next = new_price;
                    flag_next  = flag_reg || hit;
                    state_next = B_IDLE;
                    if (last_reg)
                    begin
                        paths_next   = (paths_reg == COUNT_MAX) ? paths_reg : paths_reg + 32'd1;
                        touched_next = ((flag_reg || hit) && touched_reg != COUNT_MAX)
                                     ? touched_reg + 32'd1 : touched_reg;
                        result_next.path_touched  = flag_reg || hit;
                        result_next.touched_total = touched_next;
                        result_next.paths_total   = paths_next;
                        rvalid_next  = 1'b1;
                        started_next = 1'b0;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop  = (state_reg == B_IDLE) && !q_empty;
        empty  = !rvalid_reg;
        result = result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            flag_reg    <= 1'b0;
            started_reg <= 1'b0;
            touched_reg <= '0;
            paths_reg   <= '0;
            rvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            flag_reg    <= flag_next;
            started_reg <= started_next;
            touched_reg <= touched_next;
            paths_reg   <= paths_next;
            rvalid_reg  <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            growth_reg <= q_item.growth;
            last_reg   <= q_item.last;
        end
        price_reg  <= price_next;
        phi_reg    <= price_reg * growth_reg[35:24];
        plo_reg    <= price_reg * growth_reg[23:0];
        result_reg <= result_next;
    end

endmodule
`default_nettype wire

FILE: rtl/gbt_checker.sv
// Port-level checks for gbm_barrier_touch_path, bound to the top level.
// Uses gbt_pkg for the payload types.
`default_nettype none
module gbt_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               push,
    input wire logic               full,
    input wire logic               empty,
    input wire logic               pop,
    input wire gbt_pkg::out_item_t result
);
    import gbt_pkg::*;

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed or vanished");

    a_busy_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> full)
        else $error("front end took a transaction but did not go busy");

    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.touched_total <= result.paths_total)
        else $error("touched count exceeds path count");

    a_touch_counted: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.path_touched |-> result.touched_total != 32'd0)
        else $error("touched path not counted");

endmodule

bind gbm_barrier_touch_path gbt_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
`default_nettype wire

FILE: tb/gbt_path_checker.sv
// Checker for the GBM barrier-touch path stepper: mirrors register writes,
// predicts each finished path and compares popped results. Depends on gbt_pkg.
`timescale 1ns / 1ps
module gbt_path_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic               full,
    input  wire gbt_pkg::in_item_t  sample,
    input  wire logic               empty,
    input  wire logic               pop,
    input  wire gbt_pkg::out_item_t result,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output int                      fail_count,
    output int                      paths_pending
);
    import gbt_pkg::*;

    logic [31:0]        start_q, barrier_q, drift_q;
    logic [30:0]        vol_q;
    logic [63:0]        price_q;
    logic               touch_q, started_q;
    logic [31:0]        touched_cnt, path_cnt;
    out_item_t          finished_paths[$];

    assign paths_pending = finished_paths.size();

    // Round v / d to nearest, ties away from zero.
    function automatic longint round_div(longint v, longint d);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + d / 2) / d;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint growth_factor(longint x);
        longint x2, x3, x4;
        x2 = round_div(x * x, 64'd16777216);
        x3 = round_div(x2 * x, 64'd16777216);
        x4 = round_div(x3 * x, 64'd16777216);
        return 64'd16777216 + x + round_div(x2, 2) + round_div(x3, 6) + round_div(x4, 24);
    endfunction

    task automatic advance_path(in_item_t it);
        longint    z, x, g;
        logic [63:0] hi, lo, r;
        out_item_t res;
        z = longint'(it.normal_sample);
        if (it.negate_sample)
            z = -z;
        if (!started_q)
        begin
            price_q   = {32'd0, start_q};
            touch_q   = (start_q == barrier_q);
            started_q = 1'b1;
        end
        x = longint'($signed(drift_q)) + round_div(longint'({33'd0, vol_q}) * z, 4096);
        if (x > 167772160)
            x = 167772160;
        if (x < -167772160)
            x = -167772160;
        g  = growth_factor(x);
        hi = g >>> 24;
        lo = g & 64'hFF_FFFF;
        r  = price_q * hi + ((price_q * lo + 64'h80_0000) >> 24);
        price_q = (r > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : r;
        if (barrier_q > start_q ? (price_q >= {32'd0, barrier_q})
                                : (price_q <= {32'd0, barrier_q}))
            touch_q = 1'b1;
        if (it.last_step)
        begin
            if (path_cnt != COUNT_MAX)
                path_cnt++;
            if (touch_q && touched_cnt != COUNT_MAX)
                touched_cnt++;
            res.path_touched  = touch_q;
            res.touched_total = touched_cnt;
            res.paths_total   = path_cnt;
            finished_paths.push_back(res);
            started_q = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_q = '0; barrier_q = '0; drift_q = '0; vol_q = '0;
            price_q = '0; touch_q = 1'b0; started_q = 1'b0;
            touched_cnt = '0; path_cnt = '0;
            fail_count = 0;
            finished_paths.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_START:   start_q   = cfg_data;
                    REG_BARRIER: barrier_q = cfg_data;
                    REG_DRIFT:   drift_q   = cfg_data;
                    REG_VOL:     vol_q     = cfg_data[30:0];
                    default: ;
                endcase
            end
            if (pop && !empty)
            begin
                if (finished_paths.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, result);
                    fail_count++;
                end
                else
                begin
                    out_item_t exp_res;
                    exp_res = finished_paths.pop_front();
                    if (exp_res !== result)
                    begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, exp_res, result);
                        fail_count++;
                    end
                end
            end
            if (push && !full)
                advance_path(sample);
        end
    end

endmodule

FILE: tb/tb_gbm_barrier_touch_path.sv
// Testbench top for gbm_barrier_touch_path: drives steps, register writes and
// pop pressure; gbt_path_checker does the predicting. Depends on gbt_pkg.
`timescale 1ns / 1ps
module tb_gbm_barrier_touch_path;
    import gbt_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic        full, empty;
    in_item_t    sample = '0;
    out_item_t   result;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          fail_count, paths_pending;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_off_cycles = 0;

    always #5 clk = ~clk;

    gbm_barrier_touch_path dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .sample(sample),
        .empty(empty), .pop(pop), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    gbt_path_checker chk (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .sample(sample),
        .empty(empty), .pop(pop), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .paths_pending(paths_pending)
    );

    // Receiver: pop at random; a pending hold-off keeps pop low while it counts
    // down, so the block backs up and raises full.
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            pop <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one step transaction; idle randomly first, hold push until accepted.
    // Push stays high after acceptance; the next idle cycle or wait_idle drops it.
    task automatic send_step(logic signed [15:0] z, logic neg, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push   <= 1'b1;
        sample <= '{normal_sample: z, negate_sample: neg, last_step: last};
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Write one register; the caller drops cfg_we after the last write.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Drain all results, then let the front end finish any trailing step.
    task automatic wait_idle();
        int guard;
        guard = 0;
        push <= 1'b0;
        while (paths_pending != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (80) @(posedge clk);
    endtask

    task automatic set_regs(logic [31:0] s, logic [31:0] b, logic [31:0] d,
                            logic [31:0] v);
        wait_idle();
        write_reg(REG_START, s);
        write_reg(REG_BARRIER, b);
        write_reg(REG_DRIFT, d);
        write_reg(REG_VOL, v);
        cfg_we <= 1'b0;
    endtask

    // Random path of one to max_len steps with uniformly random sample content.
    task automatic random_path(int max_len, output int n);
        n = $urandom_range(max_len, 1);
        for (int i = 0; i < n; i++)
            send_step(16'($urandom_range(65535)), 1'($urandom_range(1)), i == n - 1);
    endtask

    task automatic random_regs();
        logic [31:0] s;
        s = 32'h1000 * $urandom_range(200, 1);
        case ($urandom_range(3))
            0: set_regs(s, s, $urandom, $urandom);
            1: set_regs(s, s + $urandom_range(40000), $urandom_range(4000) - 2000,
                        $urandom_range(3000000));
            2: set_regs(s, s - $urandom_range(40000), $urandom_range(4000) - 2000,
                        $urandom_range(3000000));
            default: set_regs($urandom, $urandom, $urandom, $urandom);
        endcase
    endtask

    initial
    begin
        int sent;
        int n;
        bit pressed;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset registers, then field extremes and odd cases.
        send_step(16'sh0000, 1'b0, 1'b1);
        set_regs(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0100_0000);
        send_step(16'sh7FFF, 1'b0, 1'b0);
        send_step(16'sh8000, 1'b1, 1'b0);
        send_step(16'sh8000, 1'b0, 1'b0);
        send_step(16'shFFFF, 1'b1, 1'b1);
        // A few writes at the extremes; the block is idle here.
        set_regs(32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_step(16'sh7FFF, 1'b0, 1'b0);
        send_step(16'sh7FFF, 1'b1, 1'b1);
        set_regs(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        send_step(16'sh1234, 1'b0, 1'b1);
        set_regs(32'h0123_4000, 32'h0123_4000, 32'h0000_0000, 32'h0040_0000);
        send_step(16'sh8000, 1'b1, 1'b0);
        send_step(16'sh2000, 1'b0, 1'b1);
        wait_idle();
        write_reg(3'd7, 32'hDEAD_BEEF);
        write_reg(3'd4, 32'hFFFF_FFFF);
        cfg_we <= 1'b0;
        send_step(16'sh0001, 1'b0, 1'b1);

        // Random phases: sender busy, receiver busy, neither idles.
        sent = 0;
        pressed = 1'b0;
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 64 : 0;
            recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 31 : 0;
            while (sent < (ph + 1) * 480)
            begin
                if ($urandom_range(7) == 0)
                    random_regs();
                if (ph == 2 && !pressed)
                begin
                    hold_off_cycles = 2000;
                    pressed = 1'b1;
                end
                random_path(12, n);
                sent += n;
            end
        end
        recv_idle_pct = 0;
        wait_idle();
        if (fail_count == 0)
            $display("tb_gbm_barrier_touch_path: done, clean");
        else
            $display("tb_gbm_barrier_touch_path: done, errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_gbm_barrier_touch_path: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/gbt_pkg.sv
rtl/gbt_front.sv
rtl/gbt_queue.sv
rtl/gbt_back.sv
rtl/gbm_barrier_touch_path.sv
rtl/gbt_checker.sv
tb/gbt_path_checker.sv
tb/tb_gbm_barrier_touch_path.sv
